FILE: rtl/kway_merge_linear_scan_top_assert.svh
// assertion macros shared by the merge block
`ifndef KWAY_MERGE_LINEAR_SCAN_TOP_ASSERT_SVH
`define KWAY_MERGE_LINEAR_SCAN_TOP_ASSERT_SVH

// same-cycle implication, off during reset
`define KWM_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define KWM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/kwm_pkg.sv
package kwm_pkg;

   // block sizes
   localparam int PARTITIONS       = 8;
   localparam int PART_DEPTH       = 256;
   localparam int KEY_WIDTH        = 32;
   localparam int PAYLOAD_WIDTH    = 16;
   localparam int PART_FIELD_WIDTH = 3;
   localparam int CSR_WIDTH        = 4;

   // derived widths
   localparam int PART_BITS   = $clog2(PARTITIONS);
   localparam int CNT_BITS    = $clog2(PART_DEPTH + 1);
   localparam int STORE_DEPTH = PARTITIONS * PART_DEPTH;
   localparam int ADDR_BITS   = $clog2(STORE_DEPTH);
   localparam int REC_BITS    = KEY_WIDTH + PAYLOAD_WIDTH;

   // command queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // stream beat layout
   localparam int REQ_DATA_BITS   = PART_FIELD_WIDTH + KEY_WIDTH + PAYLOAD_WIDTH;
   localparam int REQ_TDATA_WIDTH = ((REQ_DATA_BITS + 7) / 8) * 8;
   localparam int RSP_DATA_BITS   = KEY_WIDTH + PAYLOAD_WIDTH + PART_FIELD_WIDTH;
   localparam int RSP_TDATA_WIDTH = ((RSP_DATA_BITS + 7) / 8) * 8;

   localparam logic [CSR_WIDTH-1:0] CSR_RESET = CSR_WIDTH'(8);

   typedef enum logic [1:0] {
      CMD_LOAD,
      CMD_PULL,
      CMD_SKIP
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type               kind;
      logic [PART_BITS-1:0]       part;
      logic [KEY_WIDTH-1:0]       key;
      logic [PAYLOAD_WIDTH-1:0]   payload;
   } cmd_type;

   typedef struct packed {
      logic                        done;
      logic [PART_FIELD_WIDTH-1:0] source;
      logic [PAYLOAD_WIDTH-1:0]    payload;
      logic [KEY_WIDTH-1:0]        key;
   } result_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_WAIT,
      ST_EMIT
   } state_type;

endpackage

FILE: rtl/kwm_ram.sv
module kwm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/kwm_front.sv
module kwm_front (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_tvalid,
   output logic                                    req_tready,
   input  logic                                    req_mode,
   input  logic [kwm_pkg::PART_FIELD_WIDTH-1:0]    req_partition,
   input  logic [kwm_pkg::KEY_WIDTH-1:0]           req_key,
   input  logic [kwm_pkg::PAYLOAD_WIDTH-1:0]       req_payload,
   output logic                                    q_valid,
   input  logic                                    q_pop,
   output kwm_pkg::cmd_type                        q_head
);
   import kwm_pkg::*;

   cmd_type              slot_ff [QUEUE_DEPTH];
   cmd_type              incoming;
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 push;

   // classify the beat: pull, load, or load to a partition that does not exist
   always_comb begin
      incoming.part    = PART_BITS'(req_partition);
      incoming.key     = req_key;
      incoming.payload = req_payload;
      if (req_mode) begin
         incoming.kind = CMD_PULL;
      end else if (int'(req_partition) < PARTITIONS) begin
         incoming.kind = CMD_LOAD;
      end else begin
         incoming.kind = CMD_SKIP;
      end
   end

   assign req_tready = (int'(count_ff) != QUEUE_DEPTH);
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (count_ff != '0);
   assign q_head     = slot_ff[rd_ptr_ff];

   // queue pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (int'(wr_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (int'(rd_ptr_ff) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, q_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= incoming;
      end
   end

endmodule

FILE: rtl/kwm_back.sv
`include "kway_merge_linear_scan_top_assert.svh"

module kwm_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   input  kwm_pkg::cmd_type                 q_head,
   output logic                             q_pop,
   input  logic [kwm_pkg::PART_BITS-1:0]    last_idx,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output kwm_pkg::result_type              rsp_data
);
   import kwm_pkg::*;

   state_type                state_ff, state_in;
   logic [PART_BITS-1:0]     scan_ff, scan_in;
   logic [PART_BITS-1:0]     cmp_idx_ff, cmp_idx_in;
   logic [PART_BITS-1:0]     best_src_ff, best_src_in;
   logic [CNT_BITS-1:0]      fill_ff [PARTITIONS];
   logic [CNT_BITS-1:0]      fill_in [PARTITIONS];
   logic [CNT_BITS-1:0]      rp_ff [PARTITIONS];
   logic [CNT_BITS-1:0]      rp_in [PARTITIONS];
   logic                     found_ff, found_in;
   logic                     cmp_live_ff, cmp_live_in;
   logic [KEY_WIDTH-1:0]     best_key_ff, best_key_in;
   logic [PAYLOAD_WIDTH-1:0] best_pay_ff, best_pay_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   result_type               rsp_ff, rsp_in;

   logic [PART_BITS-1:0]     sel_idx;
   logic [CNT_BITS-1:0]      sel_fill, sel_rp;
   logic                     live, fill_ok, out_free, emit, scan_step, take_better;
   logic                     ram_we;
   logic [ADDR_BITS-1:0]     ram_waddr, ram_raddr;
   logic [REC_BITS-1:0]      ram_wdata, ram_rdata;
   logic [KEY_WIDTH-1:0]     rd_key;
   logic [PAYLOAD_WIDTH-1:0] rd_pay;

   // one partition counter pair is looked at per cycle
   always_comb begin
      case (state_ff)
         ST_IDLE: sel_idx = q_head.part;
         ST_SCAN: sel_idx = scan_ff;
         default: sel_idx = best_src_ff;
      endcase
   end

   assign sel_fill = fill_ff[sel_idx];
   assign sel_rp   = rp_ff[sel_idx];
   assign live     = (sel_rp < sel_fill);
   assign fill_ok  = (int'(sel_fill) < PART_DEPTH);
   assign out_free = !rsp_valid_ff || rsp_ready;

   // record store
   assign ram_waddr = ADDR_BITS'(int'(sel_idx) * PART_DEPTH + int'(sel_fill));
   assign ram_raddr = ADDR_BITS'(int'(sel_idx) * PART_DEPTH + int'(sel_rp));
   assign ram_wdata = {q_head.payload, q_head.key};
   assign rd_key    = ram_rdata[KEY_WIDTH-1:0];
   assign rd_pay    = ram_rdata[REC_BITS-1:KEY_WIDTH];

   kwm_ram #(
      .WIDTH (REC_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid && (q_head.kind == CMD_PULL)) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_ff == last_idx) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: state_in = ST_EMIT;
         ST_EMIT: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      q_pop     = 1'b0;
      ram_we    = 1'b0;
      scan_step = 1'b0;
      emit      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            q_pop  = q_valid;
            ram_we = q_valid && (q_head.kind == CMD_LOAD) && fill_ok;
         end
         ST_SCAN: scan_step = 1'b1;
         ST_EMIT: emit = out_free;
         default: begin
            q_pop = 1'b0;
         end
      endcase
   end

   // head compare in the cycle after the store read
   assign take_better = !found_ff || ($signed(rd_key) < $signed(best_key_ff));

   // datapath next values
   always_comb begin
      fill_in      = fill_ff;
      rp_in        = rp_ff;
      scan_in      = scan_ff;
      cmp_live_in  = scan_step && live;
      cmp_idx_in   = scan_ff;
      found_in     = found_ff;
      best_key_in  = best_key_ff;
      best_pay_in  = best_pay_ff;
      best_src_in  = best_src_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;

      if (ram_we) begin
         fill_in[sel_idx] = sel_fill + 1'b1;
      end

      // scan walks partitions 0 .. last_idx
      if (q_pop) begin
         scan_in  = '0;
         found_in = 1'b0;
      end else if (scan_step && (scan_ff != last_idx)) begin
         scan_in = scan_ff + 1'b1;
      end

      if (cmp_live_ff && take_better) begin
         found_in    = 1'b1;
         best_key_in = rd_key;
         best_pay_in = rd_pay;
         best_src_in = cmp_idx_ff;
      end

      // result beat: advance the winning partition, or a done beat when none was found
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (found_ff) begin
            rp_in[sel_idx] = sel_rp + 1'b1;
            rsp_in.done    = 1'b0;
            rsp_in.source  = PART_FIELD_WIDTH'(best_src_ff);
            rsp_in.payload = best_pay_ff;
            rsp_in.key     = best_key_ff;
         end else begin
            rsp_in = '0;
            rsp_in.done = 1'b1;
         end
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         scan_ff      <= '0;
         found_ff     <= 1'b0;
         cmp_live_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < PARTITIONS; i++) begin
            fill_ff[i] <= '0;
            rp_ff[i]   <= '0;
         end
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         found_ff     <= found_in;
         cmp_live_ff  <= cmp_live_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_ff      <= fill_in;
         rp_ff        <= rp_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmp_idx_ff  <= cmp_idx_in;
      best_key_ff <= best_key_in;
      best_pay_ff <= best_pay_in;
      best_src_ff <= best_src_in;
      rsp_ff      <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `KWM_ASSERT_IMP(a_rp_within_fill, state_ff == ST_SCAN, sel_rp <= sel_fill,
      "read pointer ran past fill count")
   `KWM_ASSERT_IMP(a_cmp_from_scan, cmp_live_ff, $past(state_ff) == ST_SCAN,
      "head compare without a scan cycle before it")
   `KWM_ASSERT_IMP(a_winner_has_record, (state_ff == ST_EMIT) && found_ff,
      rp_ff[best_src_ff] < fill_ff[best_src_ff], "winning partition has no record left")
   `KWM_ASSERT_NEXT(a_emit_shows_beat, emit, rsp_valid_ff,
      "emitted result not held in output register")

endmodule

FILE: rtl/kway_merge_linear_scan_top.sv
// load beat: enters the command queue on accept, written to the record store when popped.
// pull beat: after the pop, SCAN reads one partition head per cycle from the single-read-port
// record store for the n partitions in use, then WAIT and EMIT. One load per cycle while the
// back end is idle; a pull holds the back end until its result beat is registered.
// reset (synchronous, active high) clears queue, fill counts, read pointers and the
// partition-count register (8); the record store is not cleared and needs no clearing pass.
module kway_merge_linear_scan_top (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // partition[2:0], key[34:3], payload[50:35], zero fill
   input  logic [kwm_pkg::REQ_TDATA_WIDTH-1:0]    req_tdata,
   // mode
   input  logic                                   req_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // out_key[31:0], out_payload[47:32], source[50:48], zero fill
   output logic [kwm_pkg::RSP_TDATA_WIDTH-1:0]    rsp_tdata,
   // done_res
   output logic                                   rsp_tuser,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [kwm_pkg::CSR_WIDTH-1:0]          csr_data
);
   import kwm_pkg::*;

   localparam int KEY_LO = PART_FIELD_WIDTH;
   localparam int PAY_LO = PART_FIELD_WIDTH + KEY_WIDTH;

   logic [CSR_WIDTH-1:0]     csr_ff, csr_in;
   logic [PART_BITS-1:0]     last_idx;
   logic                     q_valid, q_pop;
   cmd_type                  q_head;
   result_type               rsp_data;

   // partitions-in-use register
   assign csr_ready = 1'b1;
   assign csr_in    = (csr_valid && csr_ready) ? csr_data : csr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= CSR_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // clamp to 1 .. PARTITIONS, kept as index of the last scanned partition
   always_comb begin
      if (csr_ff == '0) begin
         last_idx = '0;
      end else if (int'(csr_ff) >= PARTITIONS) begin
         last_idx = PART_BITS'(PARTITIONS - 1);
      end else begin
         last_idx = PART_BITS'(csr_ff - 1'b1);
      end
   end

   kwm_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_mode      (req_tuser),
      .req_partition (req_tdata[PART_FIELD_WIDTH-1:0]),
      .req_key       (req_tdata[PAY_LO-1:KEY_LO]),
      .req_payload   (req_tdata[PAY_LO+PAYLOAD_WIDTH-1:PAY_LO]),
      .q_valid       (q_valid),
      .q_pop         (q_pop),
      .q_head        (q_head)
   );

   kwm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .last_idx  (last_idx),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_data  (rsp_data)
   );

   // result beat packing
   assign rsp_tdata = RSP_TDATA_WIDTH'({rsp_data.source, rsp_data.payload, rsp_data.key});
   assign rsp_tuser = rsp_data.done;

endmodule
